// ===== hdl/lpd3_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd3_pkg
// Widths, request types and fixed-point constants for the 3D point-to-line
// distance pipeline.
// ----------------------------------------------------------------------------
package lpd3_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * COORD_WIDTH + 1;
    localparam int NUM_W  = PROD_W + 2;
    localparam int DEN_W  = 2 * COORD_WIDTH;
    localparam int DIV_W  = DEN_W + COORD_WIDTH;
    localparam int E_W    = 2 * COORD_WIDTH;
    localparam int H_W    = E_W / 2;
    localparam int SQ_W   = 2 * E_W;
    localparam int SQRT_N = SQ_W / 2;
    localparam int DIST_W = COORD_WIDTH + 1;

    localparam logic [SQ_W-1:0] DIST_MAX = SQ_W'({DIST_W{1'b1}});

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] dir_z;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } query_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              degenerate;
        logic              saturated;
    } result_t;

endpackage

// ===== hdl/line_point_distance_3d.sv =====
// ----------------------------------------------------------------------------
// line_point_distance_3d
// Pipelined distance from a query point to a line given by origin and
// direction; projection by a bit-per-stage divider, length by a
// bit-per-stage integer square root.
// ----------------------------------------------------------------------------
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+------------------------
//  query    | query_valid   | query_stall   | query  (lpd3_pkg::query_t)
//  result   | result_valid  | result_stall  | result (lpd3_pkg::result_t)
//
//  One request per cycle while query_stall is low. Stages: 4 setup stages,
//  one divider stage per quotient bit (COORD_WIDTH), 6 stages for clamp,
//  error vector and squares, one square-root stage per root bit (SQ_W/2),
//  and the output reg. Reset clears valid bits only. A skid register behind
//  the output register absorbs one request; while it is full the pipeline
//  holds and query_stall is high.
// ----------------------------------------------------------------------------
module line_point_distance_3d (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              query_valid,
    output logic              query_stall,
    input  lpd3_pkg::query_t  query,
    output logic              result_valid,
    input  logic              result_stall,
    output lpd3_pkg::result_t result
);

    typedef struct packed {
        logic [2:0][lpd3_pkg::COORD_WIDTH-1:0] d;
        logic [2:0][lpd3_pkg::DIFF_W-1:0]      f;
    } geo_t;

    typedef struct packed {
        geo_t                             geo;
        logic [lpd3_pkg::DEN_W-1:0]       den;
        logic [lpd3_pkg::DIV_W-1:0]       r;
        logic [lpd3_pkg::COORD_WIDTH-1:0] q;
        logic                             neg;
        logic                             ovf;
        logic                             degen;
    } div_t;

    typedef struct packed {
        logic [lpd3_pkg::SQ_W-1:0] n;
        logic [lpd3_pkg::SQ_W-1:0] res;
        logic                      degen;
        logic                      sat;
    } root_t;

    logic pipe_en;
    logic skid_valid_reg;
    logic result_valid_reg;
    lpd3_pkg::result_t result_reg;
    lpd3_pkg::result_t skid_reg;
    lpd3_pkg::result_t tail;

    logic a_v_reg, b_v_reg, c_v_reg;
    geo_t a_geo_reg, b_geo_reg, c_geo_reg;
    logic signed [lpd3_pkg::PROD_W-1:0] b_pn_reg [3];
    logic [lpd3_pkg::DEN_W-1:0]         b_pd_reg [3];
    logic signed [lpd3_pkg::NUM_W-1:0]  c_num_reg;
    logic [lpd3_pkg::DEN_W-1:0]         c_den_reg;

    logic dv_v_reg [lpd3_pkg::COORD_WIDTH+1];
    div_t dv_reg   [lpd3_pkg::COORD_WIDTH+1];
    div_t dv_next;

    logic e_v_reg, f_v_reg, g_v_reg, h_v_reg, i_v_reg;
    geo_t e_geo_reg, f_geo_reg;
    logic [lpd3_pkg::COORD_WIDTH-1:0] e_s_reg;
    logic e_degen_reg, e_sat_reg, f_degen_reg, f_sat_reg, g_degen_reg, g_sat_reg;
    logic h_degen_reg, h_sat_reg, i_degen_reg, i_sat_reg;
    logic signed [lpd3_pkg::E_W-1:0] f_ds_reg [3];
    logic [lpd3_pkg::E_W-1:0]        g_a_reg  [3];
    logic [2*lpd3_pkg::H_W-1:0]      h_hh_reg [3];
    logic [2*lpd3_pkg::H_W-1:0]      h_hl_reg [3];
    logic [2*lpd3_pkg::H_W-1:0]      h_ll_reg [3];
    logic [lpd3_pkg::SQ_W-1:0]       i_sq_reg [3];

    logic  sr_v_reg [lpd3_pkg::SQRT_N+1];
    root_t sr_reg   [lpd3_pkg::SQRT_N+1];

    logic [lpd3_pkg::COORD_WIDTH-1:0] e_q, e_lim, e_qs;
    logic e_sat;
    logic [lpd3_pkg::NUM_W-1:0] d_mag;
    logic [lpd3_pkg::DIV_W-1:0] d_shift;
    logic [lpd3_pkg::SQ_W-1:0]  root_sh;

    assign pipe_en     = !skid_valid_reg;
    assign query_stall = skid_valid_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            dv_v_reg[0] <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
            sr_v_reg[0] <= 1'b0;
        end
        else if (pipe_en)
        begin
            a_v_reg <= query_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            dv_v_reg[0] <= c_v_reg;
            e_v_reg <= dv_v_reg[lpd3_pkg::COORD_WIDTH];
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
            sr_v_reg[0] <= i_v_reg;
        end
    end

    always_comb
    begin
        d_mag = c_num_reg[lpd3_pkg::NUM_W-1] ? lpd3_pkg::NUM_W'(-c_num_reg)
                                              : lpd3_pkg::NUM_W'(c_num_reg);
        d_shift = lpd3_pkg::DIV_W'(d_mag) << lpd3_pkg::FRAC_BITS;
        dv_next.geo   = c_geo_reg;
        dv_next.den   = c_den_reg;
        dv_next.r     = d_shift;
        dv_next.q     = '0;
        dv_next.neg   = c_num_reg[lpd3_pkg::NUM_W-1];
        dv_next.ovf   = d_shift >= (lpd3_pkg::DIV_W'(c_den_reg) << lpd3_pkg::COORD_WIDTH);
        dv_next.degen = c_den_reg == '0;
    end

    always_comb
    begin
        e_q   = dv_reg[lpd3_pkg::COORD_WIDTH].q;
        e_lim = dv_reg[lpd3_pkg::COORD_WIDTH].neg
              ? {1'b1, {(lpd3_pkg::COORD_WIDTH-1){1'b0}}}
              : {1'b0, {(lpd3_pkg::COORD_WIDTH-1){1'b1}}};
        e_sat = dv_reg[lpd3_pkg::COORD_WIDTH].ovf || (e_q > e_lim);
        e_qs  = e_sat ? e_lim : e_q;
    end

    // front stages, clamp, error vector and squares
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_geo_reg.d[0] <= query.dir_x;
            a_geo_reg.d[1] <= query.dir_y;
            a_geo_reg.d[2] <= query.dir_z;
            a_geo_reg.f[0] <= lpd3_pkg::DIFF_W'(query.point_x)
                            - lpd3_pkg::DIFF_W'(query.origin_x);
            a_geo_reg.f[1] <= lpd3_pkg::DIFF_W'(query.point_y)
                            - lpd3_pkg::DIFF_W'(query.origin_y);
            a_geo_reg.f[2] <= lpd3_pkg::DIFF_W'(query.point_z)
                            - lpd3_pkg::DIFF_W'(query.origin_z);

            b_geo_reg <= a_geo_reg;
            for (int i = 0; i < 3; i++)
            begin
                b_pn_reg[i] <= lpd3_pkg::PROD_W'($signed(a_geo_reg.d[i]))
                             * lpd3_pkg::PROD_W'($signed(a_geo_reg.f[i]));
                b_pd_reg[i] <= lpd3_pkg::DEN_W'(
                               lpd3_pkg::DEN_W'($signed(a_geo_reg.d[i]))
                             * lpd3_pkg::DEN_W'($signed(a_geo_reg.d[i])));
            end

            c_geo_reg <= b_geo_reg;
            c_num_reg <= lpd3_pkg::NUM_W'(b_pn_reg[0]) + lpd3_pkg::NUM_W'(b_pn_reg[1])
                       + lpd3_pkg::NUM_W'(b_pn_reg[2]);
            c_den_reg <= b_pd_reg[0] + b_pd_reg[1] + b_pd_reg[2];

            dv_reg[0] <= dv_next;

            e_geo_reg   <= dv_reg[lpd3_pkg::COORD_WIDTH].geo;
            e_degen_reg <= dv_reg[lpd3_pkg::COORD_WIDTH].degen;
            if (dv_reg[lpd3_pkg::COORD_WIDTH].degen)
            begin
                e_s_reg   <= '0;
                e_sat_reg <= 1'b0;
            end
            else
            begin
                e_s_reg   <= dv_reg[lpd3_pkg::COORD_WIDTH].neg ? -e_qs : e_qs;
                e_sat_reg <= e_sat;
            end

            f_geo_reg   <= e_geo_reg;
            f_degen_reg <= e_degen_reg;
            f_sat_reg   <= e_sat_reg;
            for (int i = 0; i < 3; i++)
            begin
                f_ds_reg[i] <= lpd3_pkg::E_W'($signed(e_geo_reg.d[i]))
                             * lpd3_pkg::E_W'($signed(e_s_reg));
            end

            g_degen_reg <= f_degen_reg;
            g_sat_reg   <= f_sat_reg;
            for (int i = 0; i < 3; i++)
            begin
                logic signed [lpd3_pkg::E_W-1:0] ev;
                ev = f_ds_reg[i]
                   - (lpd3_pkg::E_W'($signed(f_geo_reg.f[i])) <<< lpd3_pkg::FRAC_BITS);
                g_a_reg[i] <= ev[lpd3_pkg::E_W-1] ? lpd3_pkg::E_W'(-ev)
                                                  : lpd3_pkg::E_W'(ev);
            end

            h_degen_reg <= g_degen_reg;
            h_sat_reg   <= g_sat_reg;
            for (int i = 0; i < 3; i++)
            begin
                h_hh_reg[i] <= (2*lpd3_pkg::H_W)'(g_a_reg[i][lpd3_pkg::E_W-1:lpd3_pkg::H_W])
                             * (2*lpd3_pkg::H_W)'(g_a_reg[i][lpd3_pkg::E_W-1:lpd3_pkg::H_W]);
                h_hl_reg[i] <= (2*lpd3_pkg::H_W)'(g_a_reg[i][lpd3_pkg::E_W-1:lpd3_pkg::H_W])
                             * (2*lpd3_pkg::H_W)'(g_a_reg[i][lpd3_pkg::H_W-1:0]);
                h_ll_reg[i] <= (2*lpd3_pkg::H_W)'(g_a_reg[i][lpd3_pkg::H_W-1:0])
                             * (2*lpd3_pkg::H_W)'(g_a_reg[i][lpd3_pkg::H_W-1:0]);
            end

            i_degen_reg <= h_degen_reg;
            i_sat_reg   <= h_sat_reg;
            for (int i = 0; i < 3; i++)
            begin
                i_sq_reg[i] <= (lpd3_pkg::SQ_W'(h_hh_reg[i]) << (2*lpd3_pkg::H_W))
                             + (lpd3_pkg::SQ_W'(h_hl_reg[i]) << (lpd3_pkg::H_W + 1))
                             + lpd3_pkg::SQ_W'(h_ll_reg[i]);
            end

            sr_reg[0].n     <= i_sq_reg[0] + i_sq_reg[1] + i_sq_reg[2];
            sr_reg[0].res   <= '0;
            sr_reg[0].degen <= i_degen_reg;
            sr_reg[0].sat   <= i_sat_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < lpd3_pkg::COORD_WIDTH; j++)
    begin : g_div
        localparam int B = lpd3_pkg::COORD_WIDTH - 1 - j;
        logic [lpd3_pkg::DIV_W-1:0] dsh;
        div_t dv_step;
        assign dsh = lpd3_pkg::DIV_W'(dv_reg[j].den) << B;

        always_comb
        begin
            dv_step = dv_reg[j];
            if (dv_reg[j].r >= dsh)
            begin
                dv_step.r    = dv_reg[j].r - dsh;
                dv_step.q[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j+1] <= 1'b0;
            else if (pipe_en)
                dv_v_reg[j+1] <= dv_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
                dv_reg[j+1] <= dv_step;
        end
    end

    // integer square root, one root bit per stage
    for (genvar k = 0; k < lpd3_pkg::SQRT_N; k++)
    begin : g_root
        localparam logic [lpd3_pkg::SQ_W-1:0] ONE =
            lpd3_pkg::SQ_W'(1) << (lpd3_pkg::SQ_W - 2 - 2*k);
        logic [lpd3_pkg::SQ_W-1:0] t;
        assign t = sr_reg[k].res + ONE;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sr_v_reg[k+1] <= 1'b0;
            else if (pipe_en)
                sr_v_reg[k+1] <= sr_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                sr_reg[k+1].degen <= sr_reg[k].degen;
                sr_reg[k+1].sat   <= sr_reg[k].sat;
                if (sr_reg[k].n >= t)
                begin
                    sr_reg[k+1].n   <= sr_reg[k].n - t;
                    sr_reg[k+1].res <= (sr_reg[k].res >> 1) + ONE;
                end
                else
                begin
                    sr_reg[k+1].n   <= sr_reg[k].n;
                    sr_reg[k+1].res <= sr_reg[k].res >> 1;
                end
            end
        end
    end

    always_comb
    begin
        root_sh = sr_reg[lpd3_pkg::SQRT_N].res >> lpd3_pkg::FRAC_BITS;
        tail.distance   = (root_sh > lpd3_pkg::DIST_MAX)
                        ? lpd3_pkg::DIST_MAX[lpd3_pkg::DIST_W-1:0]
                        : root_sh[lpd3_pkg::DIST_W-1:0];
        tail.degenerate = sr_reg[lpd3_pkg::SQRT_N].degen;
        tail.saturated  = sr_reg[lpd3_pkg::SQRT_N].sat;
    end

    // output register and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!result_valid_reg || !result_stall)
            begin
                result_valid_reg <= 1'b1;
                skid_valid_reg   <= 1'b0;
            end
        end
        else if (sr_v_reg[lpd3_pkg::SQRT_N])
        begin
            if (!result_valid_reg || !result_stall)
                result_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!result_valid_reg || !result_stall)
                result_reg <= skid_reg;
        end
        else if (sr_v_reg[lpd3_pkg::SQRT_N])
        begin
            if (!result_valid_reg || !result_stall)
                result_reg <= tail;
            else
                skid_reg <= tail;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid holds a request while the output register is empty");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.degenerate && result_reg.saturated))
        else $error("degenerate and saturated both set");

    a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(sr_v_reg[lpd3_pkg::SQRT_N]))
        else $error("pipeline tail moved while held");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !result_stall) |=> !skid_valid_reg)
        else $error("skid not drained when output was free");
`endif

endmodule
